/* rtl/fprs_pkg.sv */
// ----------------------------------------------------------------------------
// fprs_pkg: shared types and constants of the false-position root step unit
// Holds the item and result beat structs, the sequencer states, the status
// codes and the register indexes of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package fprs_pkg;

	localparam int unsigned XW = 32;
	localparam int unsigned CNT_W = 17;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned DIV_STEPS = 34;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_X_ACCURACY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVALS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_EVALS = 2'd2;

	localparam logic ACTION_START = 1'b0;
	localparam logic ACTION_EVAL = 1'b1;

	typedef enum logic [1:0] {
		STATUS_EVAL = 2'd0,
		STATUS_ROOT = 2'd1,
		STATUS_OVER = 2'd2
	} status_t;

	typedef struct packed {
		logic action;
		logic signed [XW-1:0] bound_a_x;
		logic signed [XW-1:0] bound_a_f;
		logic signed [XW-1:0] bound_b_x;
		logic signed [XW-1:0] bound_b_f;
		logic signed [XW-1:0] f_value;
	} item_t;

	typedef struct packed {
		logic signed [XW-1:0] x_out;
		status_t status;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} fprs_state_t;

endpackage

`default_nettype wire

/* rtl/false_position_root_step_unit.sv */
// ----------------------------------------------------------------------------
// false_position_root_step_unit: one step of a regula falsi root search
// Holds the bracket and emits the next probe, a converged root or a budget
// overrun for every item, with a single multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Usage. An item beat on the item channel either starts a search with a new
// bracket (action 0) or brings the function value at the last probe
// (action 1). Every item gives exactly one result beat: the next probe with
// status 0, a converged root with status 1, or a budget overrun with
// status 2. The configuration channel writes the accuracy and the budget
// registers; it is always ready and must only be used while the block idles.
// Sequence: an item that needs a new probe passes from its accepting edge
// to the result register through operand preparation, the 32x32
// multiplier, the range check, the serial restoring divider (one quotient
// bit a cycle), the forming of the sum and the hand-over. A zero product
// or a saturated quotient skips the divider. An item that ends the search
// (converged or over budget) goes straight to the hand-over. One item is
// worked on at a time; item_ready is high only while the sequencer is
// idle, so a new item is taken only once the last result has been handed
// over to the result register.
// Stalls: the result register holds its beat until result_ready is seen.
// The next item may be accepted while that beat waits; its result is held
// back in the sequencer until the register frees up.
// Reset: arst_n clears the bracket, the last probe and the evaluation count
// to zero, and loads accuracy 66, budget 100 and initial count 2.
// ----------------------------------------------------------------------------
`default_nettype none

module false_position_root_step_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire fprs_pkg::item_t                item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output fprs_pkg::result_t                   result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fprs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fprs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fprs_pkg::*;

	// Configuration registers.
	logic [30:0] x_acc_q;
	logic [15:0] max_evals_q;
	logic [15:0] init_evals_q;

	// Search state kept between items.
	logic signed [XW-1:0] neg_x_q, neg_f_q, pos_x_q, pos_f_q, probe_q;
	logic [CNT_W-1:0] count_q;

	// Working registers of the probe computation.
	logic [31:0] dx_mag_q;
	logic [31:0] fl_mag_q;
	logic [32:0] den_mag_q;
	logic q_neg_q;
	logic [63:0] prod_q;
	logic [32:0] rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [5:0] bit_q;

	// Result waiting for the output register.
	logic signed [XW-1:0] res_x_q;
	status_t res_st_q;

	fprs_state_t state_q, state_d;

	logic item_fire, out_load;

	// Step decision on an evaluate beat.
	logic [CNT_W-1:0] count_inc;
	logic signed [32:0] del;
	logic [31:0] del_mag;
	logic eval_root, eval_over;

	// Operand preparation.
	logic signed [32:0] dx, den;

	// Range check and serial division.
	logic prod_zero, quo_sat;
	logic [33:0] trial;
	logic trial_ge;

	// Final sum.
	logic [33:0] q_mag;
	logic signed [35:0] q_signed, sum;
	logic signed [XW-1:0] sum_sat;

	assign cfg_ready = 1'b1;
	assign item_ready = (state_q == ST_IDLE);
	assign item_fire = item_valid && item_ready;
	assign out_load = (state_q == ST_DONE) && (!result_valid || result_ready);

	always_comb begin
		count_inc = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
		if (item.f_value < 0) begin
			del = {neg_x_q[31], neg_x_q} - {probe_q[31], probe_q};
		end else begin
			del = {pos_x_q[31], pos_x_q} - {probe_q[31], probe_q};
		end
		// The difference of two 32-bit values never exceeds 2^32 - 1 in size.
		del_mag = del[32] ? 32'(-del) : del[31:0];
		eval_root = ({1'b0, del_mag} < {2'b00, x_acc_q}) || (item.f_value == 0);
		eval_over = count_inc > {1'b0, max_evals_q};
	end

	always_comb begin
		dx = {pos_x_q[31], pos_x_q} - {neg_x_q[31], neg_x_q};
		den = {neg_f_q[31], neg_f_q} - {pos_f_q[31], pos_f_q};
	end

	always_comb begin
		prod_zero = (prod_q == 64'd0);
		// A quotient of 2^34 or more saturates anyway; a zero divisor lands here too.
		quo_sat = {3'b000, prod_q[63:34]} >= den_mag_q;
		trial = {rem_q, prod_q[bit_q]};
		trial_ge = trial >= {1'b0, den_mag_q};
	end

	always_comb begin
		q_mag = (quo_q > 34'h2_0000_0000) ? 34'h2_0000_0000 : quo_q;
		q_signed = q_neg_q ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
		sum = {{4{neg_x_q[31]}}, neg_x_q} + q_signed;
		if (sum > 36'sd2147483647) begin
			sum_sat = 32'sh7FFF_FFFF;
		end else if (sum < -36'sd2147483648) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = sum[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					if (item.action == ACTION_START) begin
						state_d = ({1'b0, init_evals_q} > {1'b0, max_evals_q}) ? ST_DONE
							: ST_PREP;
					end else begin
						state_d = (eval_root || eval_over) ? ST_DONE : ST_PREP;
					end
				end
			end
			ST_PREP: state_d = ST_MUL;
			ST_MUL: state_d = ST_CHK;
			ST_CHK: state_d = (prod_zero || quo_sat) ? ST_FIN : ST_DIV;
			ST_DIV: state_d = (bit_q == 6'd0) ? ST_FIN : ST_DIV;
			ST_FIN: state_d = ST_DONE;
			ST_DONE: state_d = out_load ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q <= 31'd66;
			max_evals_q <= 16'd100;
			init_evals_q <= 16'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_X_ACCURACY: x_acc_q <= cfg_data[30:0];
				CFG_MAX_EVALS: max_evals_q <= cfg_data[15:0];
				CFG_INIT_EVALS: init_evals_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Bracket, probe and count update on item beats and at the end of a probe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_x_q <= '0;
			neg_f_q <= '0;
			pos_x_q <= '0;
			pos_f_q <= '0;
			probe_q <= '0;
			count_q <= '0;
		end else if (item_fire) begin
			if (item.action == ACTION_START) begin
				// End a takes the negative side only when its value is negative.
				if (item.bound_a_f < 0) begin
					neg_x_q <= item.bound_a_x;
					neg_f_q <= item.bound_a_f;
					pos_x_q <= item.bound_b_x;
					pos_f_q <= item.bound_b_f;
				end else begin
					neg_x_q <= item.bound_b_x;
					neg_f_q <= item.bound_b_f;
					pos_x_q <= item.bound_a_x;
					pos_f_q <= item.bound_a_f;
				end
				count_q <= {1'b0, init_evals_q};
			end else begin
				count_q <= count_inc;
				if (item.f_value < 0) begin
					neg_x_q <= probe_q;
					neg_f_q <= item.f_value;
				end else begin
					pos_x_q <= probe_q;
					pos_f_q <= item.f_value;
				end
			end
		end else if (state_q == ST_FIN) begin
			probe_q <= sum_sat;
		end
	end

	// Datapath: operand magnitudes, product, serial quotient and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					if (item.action == ACTION_START) begin
						res_x_q <= '0;
						res_st_q <= STATUS_OVER;
					end else begin
						res_x_q <= probe_q;
						res_st_q <= eval_root ? STATUS_ROOT : STATUS_OVER;
					end
				end
			end
			ST_PREP: begin
				dx_mag_q <= dx[32] ? 32'(-dx) : dx[31:0];
				fl_mag_q <= neg_f_q[31] ? 32'(-neg_f_q) : neg_f_q;
				den_mag_q <= den[32] ? -den : den;
				q_neg_q <= dx[32] ^ neg_f_q[31] ^ den[32];
			end
			ST_MUL: begin
				prod_q <= 64'(dx_mag_q) * 64'(fl_mag_q);
			end
			ST_CHK: begin
				rem_q <= {3'b000, prod_q[63:34]};
				bit_q <= 6'(DIV_STEPS - 1);
				if (prod_zero) begin
					quo_q <= '0;
				end else if (quo_sat) begin
					quo_q <= 34'h2_0000_0000;
				end else begin
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= trial_ge ? 33'(trial - {1'b0, den_mag_q}) : trial[32:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], trial_ge};
				bit_q <= bit_q - 1'b1;
			end
			ST_FIN: begin
				res_x_q <= sum_sat;
				res_st_q <= STATUS_EVAL;
			end
			default: ;
		endcase
	end

	// Output register: holds its beat while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.x_out <= res_x_q;
			result.status <= res_st_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/fprs_checker.sv */
// ----------------------------------------------------------------------------
// fprs_checker: port-level checks of the false-position root step unit
// Watches the item and result channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module fprs_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire fprs_pkg::result_t result
);
	import fprs_pkg::*;

	// A stalled result beat keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Once an item is taken, the block is busy at the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while still working on the previous one");

	// No result appears in the cycle right after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result appeared too early");

	// Only the three status codes are ever shown.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == STATUS_EVAL || result.status == STATUS_ROOT
			|| result.status == STATUS_OVER))
		else $error("undefined status code");

endmodule

bind false_position_root_step_unit fprs_checker u_fprs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

`default_nettype wire

/* bench/false_position_root_step_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// false_position_root_step_unit_tb: self-checking bench for the root step unit
// Directed cases cover side choice, equal function values, saturation, zero
// function values, budget overruns and register writes. Random searches then
// run on linear, square and cube shaped objectives under six register
// settings and three idle patterns. A mirror of the bracket state predicts
// every result beat.
// ----------------------------------------------------------------------------

module false_position_root_step_unit_tb;

	import fprs_pkg::*;

	// The run is bounded in cycles. A correct run stays well inside the bound,
	// even with every probe paying the full divider latency and the
	// heaviest receiver stalls.
	localparam int CYCLE_LIMIT = 800000;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int MAX_REPORTED = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic signed [XW-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [XW-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [XW-1:0] Q_ONE = 32'sh0001_0000;

	// The quotient of one false-position step is clamped to plus or minus 2^33.
	localparam longint QUOTIENT_LIMIT = 64'sh2_0000_0000;

	// Shapes of the objective that the bench evaluates for each probe.
	typedef enum int {
		SHAPE_LINEAR,
		SHAPE_SQUARE,
		SHAPE_CUBE
	} shape_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item_beat;
	logic result_valid;
	logic result_ready;
	result_t result_beat;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	false_position_root_step_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item_beat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_beat),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the bracket: the side that holds the negative function value,
	// the other side, the last probe handed out and the evaluation count.
	logic signed [XW-1:0] neg_x;
	logic signed [XW-1:0] neg_f;
	logic signed [XW-1:0] pos_x;
	logic signed [XW-1:0] pos_f;
	logic signed [XW-1:0] probe_x;
	logic [CNT_W-1:0] evals;

	// Mirror of the three configuration registers.
	logic [30:0] accuracy_q;
	logic [15:0] eval_budget;
	logic [15:0] evals_at_start;

	// Results still owed by the block, oldest first.
	result_t expected_steps[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int items_sent;
	int searches;
	int probes_seen;
	int roots_seen;
	int overruns_seen;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Clamps a wide value into the signed Q16.16 range.
	function automatic logic signed [XW-1:0] clamp_q(input longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v[XW-1:0];
	endfunction

	// Next probe of the false-position rule: x = xl + dx*fl/(fl-fh). The
	// product is exact in 64 bits and the division truncates toward zero.
	// With equal function values only the sign of the product counts.
	function automatic logic signed [XW-1:0] false_position_probe();
		longint nx, nf, px, pf;
		longint span, denom, prod, quo;
		nx = neg_x;
		nf = neg_f;
		px = pos_x;
		pf = pos_f;
		span = px - nx;
		denom = nf - pf;
		prod = span * nf;
		if (denom == 0) begin
			quo = (prod > 0) ? QUOTIENT_LIMIT : ((prod < 0) ? -QUOTIENT_LIMIT : 64'sd0);
		end else begin
			quo = prod / denom;
			if (quo > QUOTIENT_LIMIT)
				quo = QUOTIENT_LIMIT;
			if (quo < -QUOTIENT_LIMIT)
				quo = -QUOTIENT_LIMIT;
		end
		return clamp_q(nx + quo);
	endfunction

	// Applies one item to the mirror and returns the result beat it causes.
	function automatic result_t advance_search(input item_t it);
		result_t r;
		longint fr, side_x, last, step, acc;
		if (it.action == ACTION_START) begin
			// The end with a negative function value goes low; if end a is not
			// negative, end b takes the low side whatever its sign.
			if ($signed(it.bound_a_f) < 0) begin
				neg_x = it.bound_a_x;
				neg_f = it.bound_a_f;
				pos_x = it.bound_b_x;
				pos_f = it.bound_b_f;
			end else begin
				neg_x = it.bound_b_x;
				neg_f = it.bound_b_f;
				pos_x = it.bound_a_x;
				pos_f = it.bound_a_f;
			end
			evals = {1'b0, evals_at_start};
			if (evals > {1'b0, eval_budget}) begin
				r.x_out = '0;
				r.status = STATUS_OVER;
				return r;
			end
			probe_x = false_position_probe();
			r.x_out = probe_x;
			r.status = STATUS_EVAL;
			return r;
		end
		if (evals != CNT_MAX)
			evals = evals + 1'b1;
		fr = $signed(it.f_value);
		last = probe_x;
		// A zero function value lands on the high side.
		if (fr < 0) begin
			side_x = neg_x;
			neg_x = probe_x;
			neg_f = it.f_value;
		end else begin
			side_x = pos_x;
			pos_x = probe_x;
			pos_f = it.f_value;
		end
		step = side_x - last;
		if (step < 0)
			step = -step;
		acc = accuracy_q;
		r.x_out = probe_x;
		if (step < acc || fr == 0) begin
			r.status = STATUS_ROOT;
			return r;
		end
		if (evals > {1'b0, eval_budget}) begin
			r.status = STATUS_OVER;
			return r;
		end
		probe_x = false_position_probe();
		r.x_out = probe_x;
		r.status = STATUS_EVAL;
		return r;
	endfunction

	// Objective evaluated by the bench at a probe, in Q16.16 with saturation.
	function automatic logic signed [XW-1:0] objective(input shape_t shape, input real root,
			input real gain, input logic signed [XW-1:0] x);
		real d, v;
		d = $itor(x) / 65536.0 - root;
		case (shape)
			SHAPE_LINEAR: v = gain * d;
			SHAPE_SQUARE: v = gain * d * ((d < 0.0) ? -d : d);
			default: v = gain * d * d * d;
		endcase
		v = v * 65536.0;
		if (v > 2147483647.0)
			v = 2147483647.0;
		if (v < -2147483648.0)
			v = -2147483648.0;
		return $rtoi(v);
	endfunction

	// Every field random; the fields an action does not use stay random too.
	function automatic item_t noise_item();
		item_t it;
		it.action = 1'($urandom_range(1));
		it.bound_a_x = $urandom;
		it.bound_a_f = $urandom;
		it.bound_b_x = $urandom;
		it.bound_b_f = $urandom;
		it.f_value = $urandom;
		return it;
	endfunction

	function automatic item_t start_item(input logic signed [XW-1:0] ax,
			input logic signed [XW-1:0] af, input logic signed [XW-1:0] bx,
			input logic signed [XW-1:0] bf);
		item_t it;
		it = noise_item();
		it.action = ACTION_START;
		it.bound_a_x = ax;
		it.bound_a_f = af;
		it.bound_b_x = bx;
		it.bound_b_f = bf;
		return it;
	endfunction

	function automatic item_t eval_item(input logic signed [XW-1:0] f);
		item_t it;
		it = noise_item();
		it.action = ACTION_EVAL;
		it.f_value = f;
		return it;
	endfunction

	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTED)
			$display("[%0t] %s: expected x_out=%h status=%0d, got x_out=%h status=%0d",
				$time, what, want.x_out, want.status, got.x_out, got.status);
	endtask

	// Sends one item beat. The sender may idle first; valid then stays high
	// with a steady payload until the accepting edge, where the result that
	// the beat causes is predicted and queued.
	task automatic push_item(input item_t it, output result_t predicted);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_beat <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predicted = advance_search(it);
		expected_steps.push_back(predicted);
		items_sent++;
	endtask

	// Drops valid and waits until every owed result has come back. Each item
	// causes exactly one result, so an empty queue means the block is idle.
	task automatic settle(input int tail);
		item_valid <= 1'b0;
		while (expected_steps.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// One register write beat; only used while the block is idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		// Bits above each register's width are dropped; the spare index is
		// ignored by the block.
		case (idx)
			CFG_X_ACCURACY: accuracy_q = data[30:0];
			CFG_MAX_EVALS: eval_budget = data[15:0];
			CFG_INIT_EVALS: evals_at_start = data[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Searches with random brackets around a random root. Each probe is
	// answered with the objective's value there or, now and then, a random
	// value; some searches are cut short and a few stray beats come in between.
	task automatic run_searches(input int goal);
		int sent, steps, root_q;
		longint span_a, span_b, xa, xb, swap_x;
		shape_t shape;
		real root, gain;
		item_t it;
		result_t got;
		sent = 0;
		while (sent < goal) begin
			if ($urandom_range(99) < 6) begin
				push_item(noise_item(), got);
				sent++;
			end else begin
				shape = shape_t'($urandom_range(2));
				root_q = $signed($urandom) >>> $urandom_range(2, 20);
				root = $itor(root_q) / 65536.0;
				gain = $urandom_range(1, 4000) / 1000.0;
				if ($urandom_range(1))
					gain = -gain;
				span_a = $urandom_range(1, 32'd1 << $urandom_range(4, 30));
				span_b = $urandom_range(1, 32'd1 << $urandom_range(4, 30));
				xa = clamp_q(longint'(root_q) - span_a);
				xb = clamp_q(longint'(root_q) + span_b);
				if ($urandom_range(1)) begin
					swap_x = xa;
					xa = xb;
					xb = swap_x;
				end
				it = start_item(xa[XW-1:0], objective(shape, root, gain, xa[XW-1:0]),
					xb[XW-1:0], objective(shape, root, gain, xb[XW-1:0]));
				push_item(it, got);
				sent++;
				searches++;
				steps = $urandom_range(4, 60);
				while (got.status == STATUS_EVAL && steps > 0 && sent < goal) begin
					if ($urandom_range(99) < 5)
						it = eval_item($urandom);
					else
						it = eval_item(objective(shape, root, gain, got.x_out));
					push_item(it, got);
					sent++;
					steps--;
				end
				// Now and then an evaluate beat arrives after the search ended.
				if (got.status != STATUS_EVAL && $urandom_range(99) < 10 && sent < goal) begin
					push_item(eval_item($urandom), got);
					sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct,
			input logic [CFG_DATA_W-1:0] accuracy, input logic [CFG_DATA_W-1:0] budget,
			input logic [CFG_DATA_W-1:0] spent);
		settle(4);
		write_register(CFG_X_ACCURACY, accuracy);
		write_register(CFG_MAX_EVALS, budget);
		write_register(CFG_INIT_EVALS, spent);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		run_searches(ITEMS_PER_PHASE);
	endtask

	// Evaluate beats straight after reset work on the all-zero bracket.
	task automatic test_unstarted_eval();
		result_t got;
		push_item(eval_item(Q_MIN), got);
		push_item(eval_item('0), got);
	endtask

	// Which end lands on the negative side, including a zero value at end a
	// and a bracket with no negative value at all.
	task automatic test_side_choice();
		result_t got;
		push_item(start_item(-2 * Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE), got);
		push_item(start_item(-2 * Q_ONE, Q_ONE, 2 * Q_ONE, -Q_ONE), got);
		push_item(start_item(Q_ONE, 3 * Q_ONE, 5 * Q_ONE, Q_ONE), got);
		push_item(start_item('0, '0, 4 * Q_ONE, -2 * Q_ONE), got);
	endtask

	// Equal function values give a zero divisor: the sign of dx*fl picks
	// the clamped quotient, and a zero product leaves the low end in place.
	task automatic test_equal_f();
		result_t got;
		push_item(start_item(3 * Q_ONE, -Q_ONE, -3 * Q_ONE, -Q_ONE), got);
		push_item(start_item(-3 * Q_ONE, -Q_ONE, 3 * Q_ONE, -Q_ONE), got);
		push_item(start_item(32'sd12345, 32'sd7, 32'sd12345, 32'sd7), got);
	endtask

	// Full-scale brackets: a divisor of minus one drives the quotient into
	// its clamp and the sum into the 32-bit limit.
	task automatic test_extremes();
		result_t got;
		push_item(start_item(Q_MIN, Q_MIN, Q_MAX, Q_MIN + 1), got);
		push_item(eval_item(Q_MAX), got);
		push_item(start_item(Q_MAX, Q_MAX, Q_MIN, Q_MIN), got);
		push_item(eval_item(Q_MIN), got);
		push_item(start_item('0, '0, '0, '0), got);
		push_item(start_item('1, '1, '1, '1), got);
		push_item(eval_item(Q_MAX), got);
	endtask

	// A function value of exactly zero ends the search as a root.
	task automatic test_zero_value();
		result_t got;
		push_item(start_item(-4 * Q_ONE, -2 * Q_ONE, 4 * Q_ONE, 2 * Q_ONE), got);
		push_item(eval_item('0), got);
	endtask

	// Budget already spent at start, and spent by the first evaluate.
	task automatic test_budget();
		result_t got;
		settle(4);
		write_register(CFG_INIT_EVALS, 32'd65535);
		write_register(CFG_MAX_EVALS, 32'd4);
		push_item(start_item(-10 * Q_ONE, -Q_ONE, 10 * Q_ONE, Q_ONE), got);
		settle(4);
		write_register(CFG_INIT_EVALS, 32'd3);
		write_register(CFG_MAX_EVALS, 32'd3);
		push_item(start_item(-10 * Q_ONE, -Q_ONE, 10 * Q_ONE, Q_ONE), got);
		push_item(eval_item(32'sd1000), got);
		settle(4);
		write_register(CFG_INIT_EVALS, 32'd65535);
		write_register(CFG_MAX_EVALS, 32'd65535);
		push_item(start_item(-10 * Q_ONE, -Q_ONE, 10 * Q_ONE, Q_ONE), got);
		push_item(eval_item(32'sd1000), got);
	endtask

	// The spare index must change nothing, and bits above each register's
	// width must be dropped. An all-ones accuracy turns any step below 2^31 - 1 into a root.
	task automatic test_register_writes();
		result_t got;
		settle(4);
		write_register(CFG_UNUSED, $urandom);
		write_register(CFG_X_ACCURACY, 32'hFFFF_FFFF);
		write_register(CFG_MAX_EVALS, 32'hFFFF_0003);
		write_register(CFG_INIT_EVALS, 32'hABCD_0001);
		push_item(start_item(-6 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE, Q_ONE), got);
		push_item(eval_item(Q_ONE), got);
	endtask

	// Six register settings, the extremes among them, over three idle
	// patterns: sender light and receiver heavy, the reverse, then none.
	task automatic test_random_searches();
		run_phase(15, 54, 32'd66, 32'd100, 32'd2);
		run_phase(15, 54, 32'd0, 32'd65535, 32'd0);
		run_phase(54, 15, 32'hFFFF_FFFF, 32'd1, 32'd0);
		run_phase(54, 15, $urandom_range(1, 4096), $urandom_range(3, 40), $urandom_range(0, 5));
		run_phase(0, 0, 32'd16, 32'd12, 32'd10);
		run_phase(0, 0, $urandom_range(0, 1 << 20), $urandom_range(1, 200),
			$urandom_range(0, 3));
	endtask

	// Every accepted result beat is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (result_valid && result_ready) begin
			if (expected_steps.size() == 0) begin
				want = '0;
				note_mismatch("result with nothing expected", want, result_beat);
			end else begin
				want = expected_steps.pop_front();
				if (result_beat.x_out !== want.x_out || result_beat.status !== want.status)
					note_mismatch("result differs", want, result_beat);
			end
			case (result_beat.status)
				STATUS_EVAL: probes_seen++;
				STATUS_ROOT: roots_seen++;
				default: overruns_seen++;
			endcase
		end
	end

	// The receiver stalls at random at the current rate.
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				expected_steps.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		item_valid <= 1'b0;
		item_beat <= '0;
		result_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		neg_x = '0;
		neg_f = '0;
		pos_x = '0;
		pos_f = '0;
		probe_x = '0;
		evals = '0;
		accuracy_q = 31'd66;
		eval_budget = 16'd100;
		evals_at_start = 16'd2;
		send_idle_pct = 15;
		recv_idle_pct = 54;
		mismatches = 0;
		items_sent = 0;
		searches = 0;
		probes_seen = 0;
		roots_seen = 0;
		overruns_seen = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unstarted_eval();
		test_side_choice();
		test_equal_f();
		test_extremes();
		test_zero_value();
		test_budget();
		test_register_writes();
		test_random_searches();

		// A quiet tail at the end catches any stray beat after the last expected one.
		settle(50);
		$display("Sent %0d item beats: directed cases and %0d random searches, six settings",
			items_sent, searches);
		$display("Checked %0d probes, %0d roots and %0d budget overruns; %0d mismatches",
			probes_seen, roots_seen, overruns_seen, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
